@@ src/assert_macros.svh @@
// Assertion macros shared by the shift/rotate unit RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define SRFU_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define SRFU_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/srfu_pkg.sv @@
// Types, constants and helper functions of the shift/rotate flag unit.
package srfu_pkg;

	localparam int unsigned DataW   = 32;
	localparam int unsigned CountW  = 5;
	localparam int unsigned AmtW    = 6;
	localparam int unsigned InTdW   = 80;
	localparam int unsigned OutTdW  = 40;

	typedef enum logic [2:0] {
		CMD_SHL  = 3'd0,
		CMD_SHR  = 3'd1,
		CMD_SAR  = 3'd2,
		CMD_ROL  = 3'd3,
		CMD_ROR  = 3'd4,
		CMD_SHLD = 3'd5,
		CMD_SHRD = 3'd6,
		CMD_PASS = 3'd7
	} cmd_t;

	typedef enum logic [1:0] {
		WID_BYTE  = 2'd0,
		WID_WORD  = 2'd1,
		WID_DWORD = 2'd2
	} wid_t;

	typedef enum logic [1:0] {
		UPD_NONE = 2'd0,
		UPD_CO   = 2'd1,
		UPD_ALL  = 2'd2
	} upd_t;

	typedef struct packed {
		cmd_t op;
		wid_t wid;
		logic a_top;
		upd_t upd;
	} ctl_t;

	function automatic logic [DataW-1:0] width_mask(input wid_t w);
		case (w)
			WID_BYTE: width_mask = 32'h0000_00ff;
			WID_WORD: width_mask = 32'h0000_ffff;
			default:  width_mask = 32'hffff_ffff;
		endcase
	endfunction

	function automatic logic top_bit(input logic [DataW-1:0] v, input wid_t w);
		case (w)
			WID_BYTE: top_bit = v[7];
			WID_WORD: top_bit = v[15];
			default:  top_bit = v[31];
		endcase
	endfunction

	function automatic logic next_bit(input logic [DataW-1:0] v, input wid_t w);
		case (w)
			WID_BYTE: next_bit = v[6];
			WID_WORD: next_bit = v[14];
			default:  next_bit = v[30];
		endcase
	endfunction

endpackage

@@ src/shift_rotate_flag_unit.sv @@
// Top level: three-stage x86 shift/rotate unit with flag results.
//
//  channel  dir  payload
//  s_axis   in   command, operand_size, operand_value, fill_value, shift_count
//  m_axis   out  result_value, carry/overflow/zero/sign/parity flags, flag_update
//
// One transfer accepted per cycle while s_axis_tready is high; stages are decode, funnel shift, flags.
// The 65-bit funnel shifter in stage 2 sets the stage depth.
// Each stage holds while the stage after it is full and stalled; s_axis_tready
// drops only when all three stages are full and m_axis_tready is low.
// arst_n clears the valid bits; data registers are not reset.
`include "assert_macros.svh"

module shift_rotate_flag_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// [2:0] command, [4:3] operand_size, [36:5] operand_value,
	// [68:37] fill_value, [76:69] shift_count, [79:77] zero
	input  logic [srfu_pkg::InTdW-1:0]    s_axis_tdata,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// [31:0] result_value, [32] carry_flag, [33] overflow_flag, [34] zero_flag,
	// [35] sign_flag, [36] parity_flag, [38:37] flag_update, [39] zero
	output logic [srfu_pkg::OutTdW-1:0]   m_axis_tdata
);

	logic adv1, adv2, adv3;

	// stage 1: decode
	srfu_pkg::cmd_t                  cmd;
	logic [1:0]                      sz;
	logic [srfu_pkg::DataW-1:0]      a, fill, am, rep, sx;
	logic [srfu_pkg::CountW-1:0]     cnt;
	logic                            dbl;
	srfu_pkg::ctl_t                  ctl;
	logic [srfu_pkg::DataW-1:0]      hi, lo;
	logic [srfu_pkg::AmtW-1:0]       amt, amt_l;

	logic                            v_s1;
	srfu_pkg::ctl_t                  ctl_s1;
	logic [srfu_pkg::DataW-1:0]      hi_s1, lo_s1;
	logic [srfu_pkg::AmtW-1:0]       amt_s1;

	// stage 2: funnel shift
	logic [2*srfu_pkg::DataW:0]      funnel;
	logic                            v_s2;
	srfu_pkg::ctl_t                  ctl_s2;
	logic [srfu_pkg::DataW+1:0]      z_s2;

	// stage 3: flags, output register
	logic [srfu_pkg::DataW-1:0]      r;
	logic                            cf, of, ztop;
	logic                            v_s3;
	logic [srfu_pkg::DataW-1:0]      res_s3;
	logic                            cf_s3, of_s3, zf_s3, sf_s3, pf_s3;
	srfu_pkg::upd_t                  upd_s3;

	assign adv3 = !v_s3 || m_axis_tready;
	assign adv2 = !v_s2 || adv3;
	assign adv1 = !v_s1 || adv2;
	assign s_axis_tready = adv1;

	always_comb begin
		cmd   = srfu_pkg::cmd_t'(s_axis_tdata[2:0]);
		sz    = s_axis_tdata[4:3];
		a     = s_axis_tdata[36:5];
		fill  = s_axis_tdata[68:37];
		cnt   = s_axis_tdata[73:69];
		dbl   = cmd inside {srfu_pkg::CMD_SHLD, srfu_pkg::CMD_SHRD};
		if (dbl) begin
			ctl.wid = srfu_pkg::WID_DWORD;
		end else begin
			case (sz)
				srfu_pkg::WID_BYTE: ctl.wid = srfu_pkg::WID_BYTE;
				srfu_pkg::WID_WORD: ctl.wid = srfu_pkg::WID_WORD;
				default:            ctl.wid = srfu_pkg::WID_DWORD;
			endcase
		end
		am = a & srfu_pkg::width_mask(ctl.wid);
		case (ctl.wid)
			srfu_pkg::WID_BYTE: begin
				rep = {4{a[7:0]}};
				sx  = {{24{a[7]}}, a[7:0]};
			end
			srfu_pkg::WID_WORD: begin
				rep = {2{a[15:0]}};
				sx  = {{16{a[15]}}, a[15:0]};
			end
			default: begin
				rep = a;
				sx  = a;
			end
		endcase
		ctl.a_top = srfu_pkg::top_bit(am, ctl.wid);
		if (cnt == '0 || cmd == srfu_pkg::CMD_PASS) begin
			ctl.op  = srfu_pkg::CMD_PASS;
			ctl.upd = srfu_pkg::UPD_NONE;
		end else if (cmd inside {srfu_pkg::CMD_ROL, srfu_pkg::CMD_ROR}) begin
			ctl.op  = cmd;
			ctl.upd = srfu_pkg::UPD_CO;
		end else begin
			ctl.op  = cmd;
			ctl.upd = srfu_pkg::UPD_ALL;
		end
		amt   = {1'b0, cnt};
		amt_l = 6'd32 - amt;
		case (ctl.op)
			srfu_pkg::CMD_SHL: begin
				hi = am; lo = '0; amt = amt_l;
			end
			srfu_pkg::CMD_SHR: begin
				hi = '0; lo = am;
			end
			srfu_pkg::CMD_SAR: begin
				hi = {srfu_pkg::DataW{ctl.a_top}}; lo = sx;
			end
			srfu_pkg::CMD_ROL: begin
				hi = rep; lo = rep; amt = amt_l;
			end
			srfu_pkg::CMD_ROR: begin
				hi = rep; lo = rep;
			end
			srfu_pkg::CMD_SHLD: begin
				hi = a; lo = fill; amt = amt_l;
			end
			srfu_pkg::CMD_SHRD: begin
				hi = fill; lo = a;
			end
			default: begin
				hi = '0; lo = am; amt = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv1) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && s_axis_tvalid) begin
			ctl_s1 <= ctl;
			hi_s1  <= hi;
			lo_s1  <= lo;
			amt_s1 <= amt;
		end
	end

	// bit 0 is the guard bit: the last bit shifted out to the right
	assign funnel = {hi_s1, lo_s1, 1'b0} >> amt_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2 && v_s1) begin
			ctl_s2 <= ctl_s1;
			z_s2   <= funnel[srfu_pkg::DataW+1:0];
		end
	end

	always_comb begin
		r    = z_s2[srfu_pkg::DataW:1] & srfu_pkg::width_mask(ctl_s2.wid);
		ztop = srfu_pkg::top_bit(r, ctl_s2.wid);
		case (ctl_s2.op)
			srfu_pkg::CMD_SHL: begin
				case (ctl_s2.wid)
					srfu_pkg::WID_BYTE: cf = z_s2[9];
					srfu_pkg::WID_WORD: cf = z_s2[17];
					default:            cf = z_s2[33];
				endcase
				of = ztop ^ cf;
			end
			srfu_pkg::CMD_SHR: begin
				cf = z_s2[0]; of = ctl_s2.a_top;
			end
			srfu_pkg::CMD_SAR: begin
				cf = z_s2[0]; of = 1'b0;
			end
			srfu_pkg::CMD_ROL: begin
				cf = r[0]; of = ztop ^ r[0];
			end
			srfu_pkg::CMD_ROR: begin
				cf = ztop; of = ztop ^ srfu_pkg::next_bit(r, ctl_s2.wid);
			end
			srfu_pkg::CMD_SHLD: begin
				cf = z_s2[33]; of = ztop ^ ctl_s2.a_top;
			end
			srfu_pkg::CMD_SHRD: begin
				cf = z_s2[0]; of = ztop ^ ctl_s2.a_top;
			end
			default: begin
				cf = 1'b0; of = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv3 && v_s2) begin
			res_s3 <= r;
			cf_s3  <= cf;
			of_s3  <= of;
			zf_s3  <= (ctl_s2.upd == srfu_pkg::UPD_ALL) && (r == '0);
			sf_s3  <= (ctl_s2.upd == srfu_pkg::UPD_ALL) && ztop;
			pf_s3  <= (ctl_s2.upd == srfu_pkg::UPD_ALL) && !(^r[7:0]);
			upd_s3 <= ctl_s2.upd;
		end
	end

	assign m_axis_tvalid = v_s3;
	assign m_axis_tdata  = {1'b0, upd_s3, pf_s3, sf_s3, zf_s3, of_s3, cf_s3, res_s3};

	`SRFU_ASSERT(a_none_no_flags,
		(m_axis_tvalid && upd_s3 == srfu_pkg::UPD_NONE) |-> (m_axis_tdata[36:32] == 5'd0),
		"flags set on a transfer that updates none")
	`SRFU_ASSERT(a_rot_no_zsp,
		(m_axis_tvalid && upd_s3 == srfu_pkg::UPD_CO) |-> (m_axis_tdata[36:34] == 3'd0),
		"zero/sign/parity set on a rotate")
	`SRFU_ASSERT(a_s2_hold,
		(v_s2 && !adv2) |=> (v_s2 && $stable(z_s2)),
		"stage 2 changed while stalled")
	`SRFU_ASSERT(a_full_when_busy,
		!s_axis_tready |-> (v_s1 && v_s2 && v_s3 && !m_axis_tready),
		"input stalled while the pipeline has room")
	`SRFU_ASSERT_ALWAYS(a_reset_empty,
		!arst_n |-> !m_axis_tvalid,
		"output valid during reset")

endmodule

@@ tb/shift_rotate_flag_unit_tb.sv @@
// Self-checking testbench for the x86 shift/rotate flag unit: directed table, then random stream.
`timescale 1ns / 100ps

module shift_rotate_flag_unit_tb;

	typedef struct packed {
		srfu_pkg::cmd_t op;
		srfu_pkg::wid_t wid;
		logic [31:0]    operand;
		logic [31:0]    fill;
		logic [7:0]     count;
	} shift_op_t;

	// bit order matches m_axis_tdata[38:0]
	typedef struct packed {
		srfu_pkg::upd_t upd;
		logic           pf;
		logic           sf;
		logic           zf;
		logic           of;
		logic           cf;
		logic [31:0]    value;
	} shift_res_t;

	typedef struct {
		shift_op_t  item;
		bit         typed;
		shift_res_t want;
	} table_row_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b1;
	logic                        s_axis_tvalid = 1'b0;
	logic                        s_axis_tready;
	logic [srfu_pkg::InTdW-1:0]  s_axis_tdata = '0;
	logic                        m_axis_tvalid;
	logic                        m_axis_tready = 1'b0;
	logic [srfu_pkg::OutTdW-1:0] m_axis_tdata;

	shift_res_t pending_results[$];
	table_row_t directed_rows[$];
	int         err_count = 0;
	int         burst_left = 0;

	shift_rotate_flag_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #1 clk = ~clk;

	function automatic shift_res_t shift_and_flags(input shift_op_t it);
		shift_res_t     res;
		int unsigned    bits, cnt, n;
		logic [31:0]    a, m, sgn, r;
		logic           cf, of, neg;
		srfu_pkg::upd_t upd;
		cnt = it.count[4:0];
		bits = (it.wid == srfu_pkg::WID_BYTE) ? 8 : (it.wid == srfu_pkg::WID_WORD) ? 16 : 32;
		m = (bits == 32) ? 32'hffff_ffff : ((32'd1 << bits) - 32'd1);
		sgn = 32'd1 << (bits - 1);
		a = it.operand;
		r = a;
		cf = 1'b0;
		of = 1'b0;
		upd = srfu_pkg::UPD_NONE;
		if (it.op == srfu_pkg::CMD_SHLD || it.op == srfu_pkg::CMD_SHRD) begin
			sgn = 32'h8000_0000;
			if (cnt != 0) begin
				if (it.op == srfu_pkg::CMD_SHLD) begin
					r = (a << cnt) | (it.fill >> (32 - cnt));
					cf = a[32 - cnt];
				end else begin
					r = (a >> cnt) | (it.fill << (32 - cnt));
					cf = a[cnt - 1];
				end
				of = r[31] ^ a[31];
				upd = srfu_pkg::UPD_ALL;
			end
		end else begin
			a = a & m;
			r = a;
			n = cnt % bits;
			if (cnt != 0 && it.op != srfu_pkg::CMD_PASS) begin
				case (it.op)
					srfu_pkg::CMD_SHL: begin
						r = (cnt >= bits) ? 32'd0 : ((a << cnt) & m);
						if (cnt <= bits)
							cf = a[bits - cnt];
						of = (|(r & sgn)) ^ cf;
						upd = srfu_pkg::UPD_ALL;
					end
					srfu_pkg::CMD_SHR: begin
						r = (cnt >= bits) ? 32'd0 : (a >> cnt);
						if (cnt <= bits)
							cf = a[cnt - 1];
						of = |(a & sgn);
						upd = srfu_pkg::UPD_ALL;
					end
					srfu_pkg::CMD_SAR: begin
						neg = |(a & sgn);
						if (cnt >= bits) begin
							r = neg ? m : 32'd0;
							cf = neg;
						end else begin
							r = (a >> cnt) | (neg ? (m ^ (m >> cnt)) : 32'd0);
							cf = a[cnt - 1];
						end
						upd = srfu_pkg::UPD_ALL;
					end
					srfu_pkg::CMD_ROL: begin
						r = (n != 0) ? (((a << n) | (a >> (bits - n))) & m) : a;
						cf = r[0];
						of = (|(r & sgn)) ^ cf;
						upd = srfu_pkg::UPD_CO;
					end
					default: begin
						r = (n != 0) ? (((a >> n) | (a << (bits - n))) & m) : a;
						cf = |(r & sgn);
						of = cf ^ (|(r & (sgn >> 1)));
						upd = srfu_pkg::UPD_CO;
					end
				endcase
			end
		end
		res = '0;
		res.value = r;
		res.cf = cf;
		res.of = of;
		res.upd = upd;
		if (upd == srfu_pkg::UPD_ALL) begin
			res.zf = (r == 32'd0);
			res.sf = |(r & sgn);
			res.pf = ~^r[7:0];
		end
		return res;
	endfunction

	function automatic shift_res_t flags_of(input logic [31:0] value, input logic cf,
			input logic of, input logic zf, input logic sf, input logic pf,
			input srfu_pkg::upd_t upd);
		shift_res_t res;
		res = '{upd: upd, pf: pf, sf: sf, zf: zf, of: of, cf: cf, value: value};
		return res;
	endfunction

	task automatic add_row(input srfu_pkg::cmd_t op, input srfu_pkg::wid_t wid,
			input logic [31:0] operand, input logic [31:0] fill, input logic [7:0] count,
			input bit typed, input shift_res_t want);
		table_row_t row;
		row.item = '{op: op, wid: wid, operand: operand, fill: fill, count: count};
		row.typed = typed;
		row.want = want;
		directed_rows.push_back(row);
	endtask

	// one transfer on s_axis; sender may idle for a random gap between bursts
	task automatic send_op(input shift_op_t it, input bit typed, input shift_res_t want);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
				: $urandom_range(1, 12);
			if (gap != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		s_axis_tdata <= {3'b000, it.count, it.fill, it.operand, it.wid, it.op};
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		pending_results.push_back(typed ? want : shift_and_flags(it));
		@(negedge clk);
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		@(negedge clk);
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic check_result(input shift_res_t want, input shift_res_t got);
		if (got.value !== want.value) begin
			err_count++;
			$display("%0t: result_value expected %h got %h", $time, want.value, got.value);
		end
		if (got.cf !== want.cf) begin
			err_count++;
			$display("%0t: carry_flag expected %b got %b", $time, want.cf, got.cf);
		end
		if (got.of !== want.of) begin
			err_count++;
			$display("%0t: overflow_flag expected %b got %b", $time, want.of, got.of);
		end
		if (got.zf !== want.zf) begin
			err_count++;
			$display("%0t: zero_flag expected %b got %b", $time, want.zf, got.zf);
		end
		if (got.sf !== want.sf) begin
			err_count++;
			$display("%0t: sign_flag expected %b got %b", $time, want.sf, got.sf);
		end
		if (got.pf !== want.pf) begin
			err_count++;
			$display("%0t: parity_flag expected %b got %b", $time, want.pf, got.pf);
		end
		if (got.upd !== want.upd) begin
			err_count++;
			$display("%0t: flag_update expected %0d got %0d", $time, want.upd, got.upd);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				err_count++;
				$display("%0t: unexpected transfer, expected none got %h", $time, m_axis_tdata);
			end else begin
				check_result(pending_results.pop_front(), shift_res_t'(m_axis_tdata[38:0]));
			end
		end
	end

	// receiver: always ready, random stalls, or a fixed 2-of-5 pattern
	initial begin
		int mode;
		int phase_left;
		int cyc;
		mode = 0;
		phase_left = 0;
		cyc = 0;
		forever begin
			@(negedge clk);
			if (phase_left == 0) begin
				mode = $urandom_range(0, 2);
				phase_left = $urandom_range(20, 80);
			end
			phase_left--;
			cyc++;
			case (mode)
				0:       m_axis_tready <= 1'b1;
				1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
				default: m_axis_tready <= ((cyc % 5) < 2);
			endcase
		end
	end

	initial begin
		#400000;
		$display("shift_rotate_flag_unit_tb: errors");
		$finish;
	end

	initial begin
		shift_op_t   it;
		int unsigned bits;
		arst_n <= 1'b0;
		add_row(srfu_pkg::CMD_SHL, srfu_pkg::WID_BYTE, 32'h0000_00ff, 32'h0, 8'd0, 1'b1,
			flags_of(32'h0000_00ff, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, srfu_pkg::UPD_NONE));
		add_row(srfu_pkg::CMD_SHL, srfu_pkg::WID_BYTE, 32'h0000_0081, 32'h0, 8'd1, 1'b1,
			flags_of(32'h0000_0002, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, srfu_pkg::UPD_ALL));
		add_row(srfu_pkg::CMD_SHL, srfu_pkg::WID_BYTE, 32'h0000_0001, 32'h0, 8'd8, 1'b1,
			flags_of(32'h0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, srfu_pkg::UPD_ALL));
		add_row(srfu_pkg::CMD_SHL, srfu_pkg::WID_WORD, 32'h0000_ffff, 32'h0, 8'd17, 1'b0, '0);
		add_row(srfu_pkg::CMD_SHL, srfu_pkg::WID_DWORD, 32'hffff_ffff, 32'h0, 8'd31, 1'b0, '0);
		add_row(srfu_pkg::CMD_SHL, srfu_pkg::WID_BYTE, 32'hffff_ff00, 32'h0, 8'd3, 1'b1,
			flags_of(32'h0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, srfu_pkg::UPD_ALL));
		add_row(srfu_pkg::CMD_SHR, srfu_pkg::WID_WORD, 32'h0000_8000, 32'h0, 8'd16, 1'b1,
			flags_of(32'h0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, srfu_pkg::UPD_ALL));
		add_row(srfu_pkg::CMD_SHR, srfu_pkg::WID_BYTE, 32'h0000_00ff, 32'h0, 8'd9, 1'b1,
			flags_of(32'h0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, srfu_pkg::UPD_ALL));
		add_row(srfu_pkg::CMD_SHR, srfu_pkg::WID_DWORD, 32'h8000_0001, 32'h0, 8'd1, 1'b0, '0);
		add_row(srfu_pkg::CMD_SAR, srfu_pkg::WID_BYTE, 32'h0000_0080, 32'h0, 8'd31, 1'b1,
			flags_of(32'h0000_00ff, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, srfu_pkg::UPD_ALL));
		add_row(srfu_pkg::CMD_SAR, srfu_pkg::WID_WORD, 32'h0000_7fff, 32'h0, 8'd16, 1'b1,
			flags_of(32'h0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, srfu_pkg::UPD_ALL));
		add_row(srfu_pkg::CMD_SAR, srfu_pkg::WID_DWORD, 32'h8000_0000, 32'h0, 8'd4, 1'b0, '0);
		add_row(srfu_pkg::CMD_SAR, srfu_pkg::WID_WORD, 32'hffff_8001, 32'h0, 8'd1, 1'b0, '0);
		add_row(srfu_pkg::CMD_ROL, srfu_pkg::WID_DWORD, 32'h8000_0000, 32'h0, 8'd1, 1'b1,
			flags_of(32'h0000_0001, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, srfu_pkg::UPD_CO));
		add_row(srfu_pkg::CMD_ROL, srfu_pkg::WID_BYTE, 32'h0000_0081, 32'h0, 8'd8, 1'b1,
			flags_of(32'h0000_0081, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, srfu_pkg::UPD_CO));
		add_row(srfu_pkg::CMD_ROL, srfu_pkg::WID_WORD, 32'h0000_1234, 32'h0, 8'd31, 1'b0, '0);
		add_row(srfu_pkg::CMD_ROR, srfu_pkg::WID_BYTE, 32'h0000_0001, 32'h0, 8'd1, 1'b1,
			flags_of(32'h0000_0080, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, srfu_pkg::UPD_CO));
		add_row(srfu_pkg::CMD_ROR, srfu_pkg::WID_WORD, 32'h0000_abcd, 32'h0, 8'd16, 1'b0, '0);
		add_row(srfu_pkg::CMD_ROR, srfu_pkg::WID_DWORD, 32'h1234_5678, 32'h0, 8'he3, 1'b0, '0);
		add_row(srfu_pkg::CMD_SHLD, srfu_pkg::WID_DWORD, 32'h1234_5678, 32'hffff_ffff, 8'd4,
			1'b1,
			flags_of(32'h2345_678f, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, srfu_pkg::UPD_ALL));
		add_row(srfu_pkg::CMD_SHRD, srfu_pkg::WID_DWORD, 32'h0000_0001, 32'h0, 8'd1, 1'b1,
			flags_of(32'h0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, srfu_pkg::UPD_ALL));
		add_row(srfu_pkg::CMD_SHLD, srfu_pkg::WID_WORD, 32'hffff_ffff, 32'h0, 8'd31, 1'b0, '0);
		add_row(srfu_pkg::CMD_SHRD, srfu_pkg::WID_DWORD, 32'h0, 32'hffff_ffff, 8'hff, 1'b0, '0);
		// double shift with a count of 32 masks to zero; byte size is ignored
		add_row(srfu_pkg::CMD_SHRD, srfu_pkg::WID_BYTE, 32'hdead_beef, 32'h5555_aaaa, 8'h20,
			1'b1,
			flags_of(32'hdead_beef, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, srfu_pkg::UPD_NONE));

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i])
			send_op(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
		wait_drained();

		for (int k = 0; k < 700; k++) begin
			if (k == 350)
				wait_drained();
			it.op = srfu_pkg::cmd_t'($urandom_range(srfu_pkg::CMD_SHL, srfu_pkg::CMD_SHRD));
			it.wid = srfu_pkg::wid_t'($urandom_range(srfu_pkg::WID_BYTE, srfu_pkg::WID_DWORD));
			bits = 8 << it.wid;
			case ($urandom_range(0, 5))
				0:       it.operand = 32'h0;
				1:       it.operand = 32'hffff_ffff;
				2:       it.operand = 32'd1 << $urandom_range(0, 31);
				default: it.operand = $urandom;
			endcase
			case ($urandom_range(0, 3))
				0:       it.fill = 32'h0;
				1:       it.fill = 32'hffff_ffff;
				default: it.fill = $urandom;
			endcase
			case ($urandom_range(0, 3))
				0: it.count = 8'($urandom_range(0, 255));
				1: it.count = {3'($urandom), 5'(bits - 1 + $urandom_range(0, 2))};
				2: it.count = {3'($urandom), 5'($urandom_range(0, 31))};
				default: it.count = 8'($urandom_range(1, 3));
			endcase
			send_op(it, 1'b0, '0);
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (err_count == 0)
			$display("shift_rotate_flag_unit_tb: clean");
		else
			$display("shift_rotate_flag_unit_tb: errors");
		$finish;
	end

endmodule
